### sv/mct_pkg.sv
// Shared types and constants of the multichannel capture tachometer.
// No dependencies; used by mct_div and multichannel_capture_tachometer.
`default_nettype none

package mct_pkg;

  localparam int NUM_CHANNELS = 9;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int SPEED_W   = 26;
  localparam int DIV_W     = 27;
  localparam int DIV_STEPS = SPEED_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [SPEED_W-1:0] RPM_NUMERATOR = 26'd60000000;

  localparam logic [10:0] PPR_RESET   = 11'd200;
  localparam logic [15:0] MINP_RESET  = 16'd100;
  localparam logic [7:0]  LIMIT_RESET = 8'd10;

  localparam logic [1:0] REG_PPR   = 2'd0;
  localparam logic [1:0] REG_MINP  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_DIVGO,
    S_DIVWAIT,
    S_EDGE_DONE,
    S_TICK
  } mct_state_t;

endpackage

`default_nettype wire

### sv/multichannel_capture_tachometer.sv
// Top level of the multichannel capture tachometer: sequencer, channel state, output register.
// Depends on mct_pkg and mct_div.
//
// Usage:
//   Input channel (in_valid / in_stall): op, channel, capture_value. An edge item
//   (op 0) measures the period since the channel's stored reference and answers one
//   result. A tick item (op 1) ages every channel's stall count and answers one
//   result per channel, in index order, the final one flagged by last.
//   Output channel (out_valid / out_stall): channel_id, speed, kind, last, held in an
//   output register so the next item is taken while a result still waits.
//   Configuration: cfg_write with cfg_index (0 pulses_per_rev, 1 min_period,
//   2 stall_limit) and cfg_data; write only while the block is idle.
// Sequence:
//   An accepted edge runs through acceptance, period and multiply, divider start,
//   26 divider steps (one quotient bit per cycle in the shared serial divider),
//   completion and state write; a rejected edge ends at the period check. A tick
//   walks the channels in index order, one channel per cycle while the output is free.
//   in_stall is high while an item is at work. Each result is registered once the output
//   register is free: from S_EDGE (rejected edge), S_TICK (tick) or S_EDGE_DONE (accepted edge).
// Reset: rst clears channel state to zero, loads the register defaults (200, 100, 10)
//   and empties the output register.
// Stall: an out_stall holds the result in the output register and the sequencer
//   waits at the point where it would emit the next one.
`default_nettype none

module multichannel_capture_tachometer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [3:0]  channel,
  input  wire logic [15:0] capture_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       channel_id,
  output logic [25:0]      speed,
  output logic [1:0]       kind,
  output logic             last,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int N = mct_pkg::NUM_CHANNELS;
  localparam int W = mct_pkg::CH_W;

  // configuration
  logic [10:0] pulses_per_rev;
  logic [15:0] min_period;
  logic [7:0]  stall_limit;

  // per-channel state
  logic [15:0]                  reference_capture [N];
  logic [mct_pkg::SPEED_W-1:0]  channel_speed     [N];
  logic [7:0]                   stall_count       [N];

  // latched item and sequencer
  mct_pkg::mct_state_t state, state_next;
  logic [3:0]   ch_q;
  logic [15:0]  cap_q;
  logic [W-1:0] idx;
  logic [mct_pkg::DIV_W-1:0] divisor_q;

  // datapath
  logic [W-1:0]                rd_idx;
  logic                        ch_ok;
  logic [15:0]                 ref_rd;
  logic [mct_pkg::SPEED_W-1:0] spd_rd;
  logic [7:0]                  stall_rd;
  logic [15:0]                 period;
  logic                        too_short;
  logic [10:0]                 ppr_eff;
  logic [mct_pkg::DIV_W-1:0]   product;
  logic [7:0]                  cnt_raised;
  logic [mct_pkg::SPEED_W-1:0] tick_speed;
  logic                        idx_last;
  logic                        out_free;

  // control from the sequencer
  logic                        emit;
  logic [3:0]                  emit_ch;
  logic [mct_pkg::SPEED_W-1:0] emit_speed;
  logic [1:0]                  emit_kind;
  logic                        emit_last;
  logic                        load_divisor;
  logic                        div_start;
  logic                        edge_write;
  logic                        tick_write;

  logic                        div_done;
  logic [mct_pkg::SPEED_W-1:0] quotient;

  mct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divisor_q),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_stall = (state != mct_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Read one channel: the tick walk index, or the edge's channel when it is in range.
  always_comb begin
    ch_ok = (5'(ch_q) < 5'(N));
    if (state == mct_pkg::S_TICK) begin
      rd_idx = idx;
    end else if (ch_ok) begin
      rd_idx = ch_q[W-1:0];
    end else begin
      rd_idx = '0;
    end
    ref_rd   = reference_capture[rd_idx];
    spd_rd   = channel_speed[rd_idx];
    stall_rd = stall_count[rd_idx];

    // period wraps modulo 2^16; zero is always a glitch
    period    = cap_q - ref_rd;
    too_short = (period == 16'd0) || (period < min_period);
    ppr_eff   = (pulses_per_rev == 11'd0) ? 11'd1 : pulses_per_rev;
    product   = {11'b0, period} * {16'b0, ppr_eff};

    // saturate the stall count at the limit, zero speed once it is reached
    cnt_raised = (stall_rd < stall_limit) ? stall_rd + 8'd1 : stall_rd;
    tick_speed = (cnt_raised >= stall_limit) ? '0 : spd_rd;
    idx_last   = (idx == W'(N - 1));
  end

  // Sequencer: next state and control strobes.
  always_comb begin
    state_next   = state;
    emit         = 1'b0;
    emit_ch      = ch_q;
    emit_speed   = spd_rd;
    emit_kind    = mct_pkg::KIND_REJECT;
    emit_last    = 1'b1;
    load_divisor = 1'b0;
    div_start    = 1'b0;
    edge_write   = 1'b0;
    tick_write   = 1'b0;
    case (state)
      mct_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (op == mct_pkg::OP_TICK) ? mct_pkg::S_TICK : mct_pkg::S_EDGE;
        end
      end
      mct_pkg::S_EDGE: begin
        if (!ch_ok || too_short) begin
          // reject: report the stored speed (zero for a channel beyond the range)
          if (out_free) begin
            emit       = 1'b1;
            emit_speed = ch_ok ? spd_rd : '0;
            state_next = mct_pkg::S_IDLE;
          end
        end else begin
          load_divisor = 1'b1;
          state_next   = mct_pkg::S_DIVGO;
        end
      end
      mct_pkg::S_DIVGO: begin
        div_start  = 1'b1;
        state_next = mct_pkg::S_DIVWAIT;
      end
      mct_pkg::S_DIVWAIT: begin
        if (div_done) begin
          state_next = mct_pkg::S_EDGE_DONE;
        end
      end
      mct_pkg::S_EDGE_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          edge_write = 1'b1;
          emit_speed = quotient;
          emit_kind  = mct_pkg::KIND_ACCEPT;
          state_next = mct_pkg::S_IDLE;
        end
      end
      mct_pkg::S_TICK: begin
        if (out_free) begin
          emit       = 1'b1;
          tick_write = 1'b1;
          emit_ch    = 4'(idx);
          emit_speed = tick_speed;
          emit_kind  = mct_pkg::KIND_TICK;
          emit_last  = idx_last;
          if (idx_last) begin
            state_next = mct_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = mct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the item, walk index and divisor.
  always_ff @(posedge clk) begin
    if (state == mct_pkg::S_IDLE && in_valid) begin
      ch_q  <= channel;
      cap_q <= capture_value;
      idx   <= '0;
    end else if (tick_write && !idx_last) begin
      idx <= idx + W'(1);
    end
    if (load_divisor) begin
      divisor_q <= product;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_rev <= mct_pkg::PPR_RESET;
      min_period     <= mct_pkg::MINP_RESET;
      stall_limit    <= mct_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mct_pkg::REG_PPR:   pulses_per_rev <= cfg_data[10:0];
        mct_pkg::REG_MINP:  min_period     <= cfg_data;
        mct_pkg::REG_LIMIT: stall_limit    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Channel state: clear at reset, update on an accepted edge or a tick step.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        reference_capture[i] <= '0;
        channel_speed[i]     <= '0;
        stall_count[i]       <= '0;
      end
    end else if (edge_write) begin
      reference_capture[rd_idx] <= cap_q;
      channel_speed[rd_idx]     <= quotient;
      stall_count[rd_idx]       <= '0;
    end else if (tick_write) begin
      stall_count[rd_idx]   <= cnt_raised;
      channel_speed[rd_idx] <= tick_speed;
    end
  end

  // Output register: load on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      channel_id <= emit_ch;
      speed      <= emit_speed;
      kind       <= emit_kind;
      last       <= emit_last;
    end
  end

endmodule

`default_nettype wire

### sv/mct_div.sv
// Bit-serial restoring divider: RPM numerator over a 27-bit divisor.
// Depends on mct_pkg for widths and the numerator constant.
`default_nettype none

module mct_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mct_pkg::DIV_W-1:0]     divisor,
  output logic                               done,
  output logic [mct_pkg::SPEED_W-1:0]        quotient
);

  logic                          busy;
  logic [mct_pkg::DIV_W-1:0]     dvs;
  logic [mct_pkg::DIV_W-1:0]     rem;
  logic [mct_pkg::DIV_W-1:0]     rem_next;
  logic [mct_pkg::SPEED_W-1:0]   num_sh;
  logic [mct_pkg::STEP_W-1:0]    step;
  logic [mct_pkg::DIV_W:0]       trial;
  logic                          fit;

  // one quotient bit a cycle: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial    = {rem, num_sh[mct_pkg::SPEED_W-1]};
    fit      = trial >= {1'b0, dvs};
    rem_next = fit ? mct_pkg::DIV_W'(trial - {1'b0, dvs}) : trial[mct_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        dvs      <= divisor;
        rem      <= '0;
        num_sh   <= mct_pkg::RPM_NUMERATOR;
        quotient <= '0;
        step     <= mct_pkg::STEP_W'(mct_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        rem      <= rem_next;
        num_sh   <= {num_sh[mct_pkg::SPEED_W-2:0], 1'b0};
        quotient <= {quotient[mct_pkg::SPEED_W-2:0], fit};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - mct_pkg::STEP_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

### verif/tb_multichannel_capture_tachometer.sv
// Self-checking testbench of the multichannel capture tachometer: a directed stimulus
// table, then random phases under several register settings, all checked by a predictor.
// Depends on mct_pkg and multichannel_capture_tachometer.

module tb_multichannel_capture_tachometer;

  localparam int IDLE_SETTLE  = 8;       // cycles after the last result before a write
  localparam int DRAIN_LIMIT  = 20000;   // cycles allowed for the block to empty
  localparam int END_SETTLE   = 40;      // cycles after the final drain
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 49;
  localparam int LONG_HOLD    = 300;     // receiver hold-off while the sender keeps offering

  // One result item as the block reports it.
  typedef struct packed {
    logic [3:0]  channel_id;
    logic [25:0] speed;
    logic [1:0]  kind;
    logic        last;
  } tach_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_action_t;

  // One row of the directed table: either an input item or a register write.
  typedef struct packed {
    row_action_t action;
    logic        op;
    logic [3:0]  chan;
    logic [15:0] value;
    logic [1:0]  reg_idx;
    bit          typed;
    logic [1:0]  want_kind;
    logic [25:0] want_speed;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [3:0]  channel;
  logic [15:0] capture_value;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  channel_id;
  logic [25:0] speed;
  logic [1:0]  kind;
  logic        last;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: per-channel reference capture, speed and tick age, plus registers.
  logic [15:0] last_capture [mct_pkg::NUM_CHANNELS];
  logic [25:0] rpm_now      [mct_pkg::NUM_CHANNELS];
  logic [7:0]  idle_ticks   [mct_pkg::NUM_CHANNELS];
  logic [10:0] ppr_reg;
  logic [15:0] min_period_reg;
  logic [7:0]  limit_reg;

  tach_result_t pending_reports[$];
  stim_row_t    directed_rows[$];

  int mismatches  = 0;
  int in_gap_pct  = 30;
  int out_gap_pct = 30;
  int hold_len    = 0;
  bit quiet       = 1'b0;

  multichannel_capture_tachometer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .channel      (channel),
    .capture_value(capture_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel_id   (channel_id),
    .speed        (speed),
    .kind         (kind),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest correct run.
  initial begin : watchdog
    #3000000;
    $display("tb: failure");
    $finish;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want)
      note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Work out the results of one accepted item and queue them in order.
  task automatic compute_reports(input logic op_i, input logic [3:0] ch_i,
                                 input logic [15:0] cap_i);
    logic [15:0]  period;
    logic [31:0]  divisor;
    tach_result_t r;
    int           i;
    if (op_i == mct_pkg::OP_EDGE) begin
      r.channel_id = ch_i;
      r.last = 1'b1;
      if (ch_i >= mct_pkg::NUM_CHANNELS) begin
        // Channel out of range: touch nothing, answer a zero-speed reject.
        r.speed = '0;
        r.kind = mct_pkg::KIND_REJECT;
      end else begin
        period = cap_i - last_capture[ch_i];
        // A zero period is a reject even when the minimum is zero.
        if (period == 16'd0 || period < min_period_reg) begin
          r.speed = rpm_now[ch_i];
          r.kind = mct_pkg::KIND_REJECT;
        end else begin
          // Treat zero pulses per revolution as one.
          divisor = 32'(period) * ((ppr_reg == 11'd0) ? 32'd1 : 32'(ppr_reg));
          rpm_now[ch_i] = 26'(32'(mct_pkg::RPM_NUMERATOR) / divisor);
          last_capture[ch_i] = cap_i;
          idle_ticks[ch_i] = 8'd0;
          r.speed = rpm_now[ch_i];
          r.kind = mct_pkg::KIND_ACCEPT;
        end
      end
      pending_reports.push_back(r);
    end else begin
      for (i = 0; i < mct_pkg::NUM_CHANNELS; i++) begin
        // Age only below the limit; a count at or past it stays and zeroes the speed.
        if (idle_ticks[i] < limit_reg)
          idle_ticks[i] = idle_ticks[i] + 8'd1;
        if (idle_ticks[i] >= limit_reg)
          rpm_now[i] = '0;
        r.channel_id = 4'(i);
        r.speed = rpm_now[i];
        r.kind = mct_pkg::KIND_TICK;
        r.last = (i == mct_pkg::NUM_CHANNELS - 1);
        pending_reports.push_back(r);
      end
    end
  endtask

  // Offer one item from a falling edge, hold it until taken, then maybe idle.
  task automatic send_item(input logic op_i, input logic [3:0] ch_i, input logic [15:0] cap_i,
                           input bit typed, input logic [1:0] want_kind,
                           input logic [25:0] want_speed);
    tach_result_t r;
    op <= op_i;
    channel <= ch_i;
    capture_value <= cap_i;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    compute_reports(op_i, ch_i, cap_i);
    if (typed) begin
      // Override with the hand-written value of this row.
      r = pending_reports.pop_back();
      r.kind = want_kind;
      r.speed = want_speed;
      pending_reports.push_back(r);
    end
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // Drop valid, wait for every queued result, then let the block settle.
  task automatic wait_idle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (pending_reports.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      mct_pkg::REG_PPR:   ppr_reg = data[10:0];
      mct_pkg::REG_MINP:  min_period_reg = data;
      mct_pkg::REG_LIMIT: limit_reg = data[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic stim_row_t item_row(input logic op_i, input logic [3:0] ch_i,
                                         input logic [15:0] cap_i);
    stim_row_t row;
    row = '0;
    row.action = ROW_ITEM;
    row.op = op_i;
    row.chan = ch_i;
    row.value = cap_i;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [3:0] ch_i, input logic [15:0] cap_i,
                                          input logic [1:0] k, input logic [25:0] s);
    stim_row_t row;
    row = item_row(mct_pkg::OP_EDGE, ch_i, cap_i);
    row.typed = 1'b1;
    row.want_kind = k;
    row.want_speed = s;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [15:0] data);
    stim_row_t row;
    row = '0;
    row.action = ROW_REG;
    row.reg_idx = idx;
    row.value = data;
    return row;
  endfunction

  // Receiver: random stall bursts, plus a long hold-off counted here on request.
  initial begin : result_side
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet)
        burst = 0;
      if (hold_len > 0) begin
        hold_len--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < out_gap_pct) begin
        burst = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    tach_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected result on channel %0d kind %0d",
                                channel_id, kind));
      end else begin
        want = pending_reports.pop_front();
        compare_field($sformatf("ch%0d channel_id", want.channel_id),
                      channel_id, want.channel_id);
        compare_field($sformatf("ch%0d speed", want.channel_id), speed, want.speed);
        compare_field($sformatf("ch%0d kind", want.channel_id), kind, want.kind);
        compare_field($sformatf("ch%0d last", want.channel_id), last, want.last);
      end
    end
  end

  initial begin : stimulus
    int          p;
    int          k;
    int          i;
    int unsigned pick;
    int unsigned min_p;
    int unsigned period;
    logic [3:0]  ch_r;
    logic [15:0] cap_r;
    logic [10:0] ppr_v;
    logic [15:0] min_v;
    logic [7:0]  lim_v;
    stim_row_t   row;

    // Drive every input from time zero; hold reset first.
    rst = 1'b1;
    in_valid = 1'b0;
    op = mct_pkg::OP_EDGE;
    channel = '0;
    capture_value = '0;
    cfg_write = 1'b0;
    cfg_index = mct_pkg::REG_PPR;
    cfg_data = '0;
    ppr_reg = mct_pkg::PPR_RESET;
    min_period_reg = mct_pkg::MINP_RESET;
    limit_reg = mct_pkg::LIMIT_RESET;
    for (i = 0; i < mct_pkg::NUM_CHANNELS; i++) begin
      last_capture[i] = '0;
      rpm_now[i] = '0;
      idle_ticks[i] = '0;
    end

    // Directed part, under the reset registers first.
    directed_rows.push_back(typed_row(4'd0, 16'd0, mct_pkg::KIND_REJECT, 26'd0)); // zero period
    directed_rows.push_back(typed_row(4'd0, 16'd99, mct_pkg::KIND_REJECT, 26'd0)); // just short
    directed_rows.push_back(typed_row(4'd0, 16'd100, mct_pkg::KIND_ACCEPT, 26'd3000)); // minimum
    directed_rows.push_back(typed_row(4'd15, 16'hFFFF, mct_pkg::KIND_REJECT, 26'd0)); // no channel
    directed_rows.push_back(typed_row(4'd9, 16'h1234, mct_pkg::KIND_REJECT, 26'd0)); // first unused
    directed_rows.push_back(typed_row(4'd8, 16'hFFFF, mct_pkg::KIND_ACCEPT, 26'd4)); // longest
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd8, 16'h0063)); // timer wrap
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd0, 16'd0));
    directed_rows.push_back(reg_row(mct_pkg::REG_PPR, 16'd1));
    directed_rows.push_back(reg_row(mct_pkg::REG_MINP, 16'd1));
    directed_rows.push_back(typed_row(4'd1, 16'd1, mct_pkg::KIND_ACCEPT, 26'd60000000)); // top
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd1, 16'd1));
    directed_rows.push_back(reg_row(mct_pkg::REG_MINP, 16'd0));
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd1, 16'd1)); // zero period, zero min
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd2, 16'h8000));
    directed_rows.push_back(reg_row(mct_pkg::REG_PPR, 16'hF800)); // masks to zero pulses
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd3, 16'd2));
    directed_rows.push_back(reg_row(mct_pkg::REG_PPR, 16'h07FF));
    directed_rows.push_back(reg_row(mct_pkg::REG_MINP, 16'hFFFF));
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd4, 16'hFFFE));
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd5, 16'hFFFF)); // quotient rounds to 0
    directed_rows.push_back(reg_row(mct_pkg::REG_MINP, 16'd1));
    directed_rows.push_back(reg_row(mct_pkg::REG_PPR, 16'd200));
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd7, 16'd500));
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd0, 16'd0));
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd0, 16'd0));
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd0, 16'd0));
    directed_rows.push_back(reg_row(mct_pkg::REG_LIMIT, 16'hFF02)); // counts now past the limit
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd0, 16'd0));
    directed_rows.push_back(reg_row(mct_pkg::REG_LIMIT, 16'd0)); // zero limit
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd0, 16'd0));
    directed_rows.push_back(reg_row(mct_pkg::REG_LIMIT, 16'd255));
    directed_rows.push_back(item_row(mct_pkg::OP_EDGE, 4'd6, 16'hFFFF));
    directed_rows.push_back(item_row(mct_pkg::OP_TICK, 4'd15, 16'hFFFF)); // ignored fields set

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.action == ROW_REG) begin
        wait_idle();
        write_reg(row.reg_idx, row.value);
      end else begin
        send_item(row.op, row.chan, row.value, row.typed, row.want_kind, row.want_speed);
      end
    end

    // Random phases: rewrite all registers, pick idle rates, then mostly
    // well-formed edges that step each channel's timer by a legal period.
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          ppr_v = 11'd1;
          min_v = 16'd1;
          lim_v = 8'd255;
        end
        1: begin
          ppr_v = 11'd1024;
          min_v = 16'd65535;
          lim_v = 8'd1;
        end
        2: begin
          ppr_v = 11'd0;
          min_v = 16'd0;
          lim_v = 8'd0;
        end
        default: begin
          ppr_v = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
          min_v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20))
                                              : 16'($urandom_range(50, 3000));
          lim_v = ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom_range(1, 12));
        end
      endcase
      write_reg(mct_pkg::REG_PPR, {5'($urandom), ppr_v});
      write_reg(mct_pkg::REG_MINP, min_v);
      write_reg(mct_pkg::REG_LIMIT, {8'($urandom), lim_v});

      // No idling at all in the last phase.
      quiet = (p == PHASES - 1);
      pick = $urandom_range(0, 2);
      in_gap_pct = quiet ? 0 : (pick == 0 ? 0 : (pick == 1 ? 25 : 60));
      pick = $urandom_range(0, 2);
      out_gap_pct = quiet ? 0 : (pick == 0 ? 0 : (pick == 1 ? 25 : 60));

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Hold off the receiver while items keep coming, so the block backs up.
        if (p == 3 && k == 5)
          hold_len = LONG_HOLD;
        // Pause the sender once until every result is out.
        if (p == 4 && k == 25)
          wait_idle();

        if ($urandom_range(0, 4) == 0) begin
          send_item(mct_pkg::OP_TICK, 4'($urandom), 16'($urandom), 1'b0,
                    mct_pkg::KIND_ACCEPT, '0);
        end else begin
          ch_r = ($urandom_range(0, 9) == 0)
                 ? 4'($urandom_range(mct_pkg::NUM_CHANNELS, 15))
                 : 4'($urandom_range(0, mct_pkg::NUM_CHANNELS - 1));
          if (ch_r >= mct_pkg::NUM_CHANNELS) begin
            cap_r = 16'($urandom);
          end else begin
            min_p = (min_period_reg == 16'd0) ? 1 : min_period_reg;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
              period = $urandom_range(min_p, 65535);
            end else if (pick < 8) begin
              // Near the minimum: short periods give high speeds.
              period = min_p + $urandom_range(0, 40);
              if (period > 65535)
                period = 65535;
            end else if (pick < 9) begin
              period = $urandom_range(0, min_p - 1);
            end else begin
              period = $urandom;
            end
            cap_r = last_capture[ch_r] + 16'(period);
          end
          send_item(mct_pkg::OP_EDGE, ch_r, cap_r, 1'b0, mct_pkg::KIND_ACCEPT, '0);
        end
      end
    end

    // Drain, flag anything still owed, and watch for strays a while longer.
    wait_idle();
    if (pending_reports.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    repeat (END_SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
